// ----- design/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared constants, codes, payload structs and slot index helpers.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TID_W = 4;
  localparam int PID_W = 8;
  localparam int TS_W = 8;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [TS_W-1:0] TIMESLICE_RESET = 8'd5;

  typedef enum logic [2:0] {
    ACT_CREATE    = 3'd0,
    ACT_DELETE    = 3'd1,
    ACT_YIELD     = 3'd2,
    ACT_BLOCK     = 3'd3,
    ACT_UNBLOCK   = 3'd4,
    ACT_PBLOCK    = 3'd5,
    ACT_PUNBLOCK  = 3'd6,
    ACT_TICK      = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_OTHER  = 3'd3,
    ST_IDLE      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_FREE,
    S_NEXT,
    S_OWN_RUN,
    S_OWN_NEW,
    S_SWITCH,
    S_PRD,
    S_PCMP,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [TID_W-1:0]  thread_id;
    logic [PID_W-1:0]  process_id;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [TID_W-1:0]  new_thread;
    logic [TID_W-1:0]  running_thread;
    logic              running_valid;
    logic              switched;
    logic              space_switch;
  } rsp_t;

  function automatic logic [SLOT_W-1:0] tid_to_slot(input logic [TID_W-1:0] tid);
    logic [SLOT_W+TID_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, tid};
    return wide[SLOT_W-1:0];
  endfunction

  function automatic logic [TID_W-1:0] slot_to_tid(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+TID_W-1:0] wide;
    wide = {{TID_W{1'b0}}, slot};
    return wide[TID_W-1:0];
  endfunction

  function automatic logic tid_in_range(input logic [TID_W-1:0] tid);
    return 32'(tid) < NUM_SLOTS;
  endfunction

endpackage

// ----- design/round_robin_thread_scheduler.sv -----
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Slot table with used, ready and wake bits, owner memory and a scan sequencer.
// ----------------------------------------------------------------------------
// Requests arrive on req with req_valid; a transaction completes when req_valid
// is high and req_stall is low. Each request yields exactly one response on rsp
// with rsp_valid, taken when rsp_stall is low. The timeslice register is
// written through cfg_we and cfg_data; the user writes it only while the
// block is idle, and the block does not enforce this. One slot index register
// steps through the table, one slot per cycle in the create and reschedule
// searches, while the process scans read and then compare each owner before
// stepping. Create searches for a free slot; a reschedule does a circular search
// plus two owner memory reads; process block and unblock read every owner.
// The block takes one request at a time; req_stall is high from acceptance
// until the response is loaded into the output register, so the next request
// can be accepted while that response waits for the receiver.
// A stalled response holds its value, and the sequencer waits in its final
// state until the output register is free.
// Reset clears the slot bits, the running thread, the tick counter and the
// timeslice (back to 5 ticks). Owner entries need no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  rrts_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output rrts_pkg::rsp_t                 rsp,
  input  logic                           cfg_we,
  input  logic [rrts_pkg::TS_W-1:0]      cfg_data
);

  rrts_pkg::state_t state, state_next;

  logic [rrts_pkg::NUM_SLOTS-1:0] used;
  logic [rrts_pkg::NUM_SLOTS-1:0] ready;
  logic [rrts_pkg::NUM_SLOTS-1:0] wake;
  logic [rrts_pkg::SLOT_W-1:0]    run;
  logic                           running;
  logic [rrts_pkg::TS_W-1:0]      tick_count;
  logic [rrts_pkg::TS_W-1:0]      timeslice;

  rrts_pkg::action_t              op;
  logic [rrts_pkg::TID_W-1:0]     tid;
  logic [rrts_pkg::PID_W-1:0]     pid;
  logic [rrts_pkg::SLOT_W-1:0]    idx;
  logic [rrts_pkg::SLOT_W-1:0]    cnt;
  rrts_pkg::status_t              status;
  logic [rrts_pkg::TID_W-1:0]     newt;
  logic                           sw;
  logic                           sp;
  logic                           any;
  logic [rrts_pkg::PID_W-1:0]     owner_a;

  logic [rrts_pkg::PID_W-1:0]     slot_owner [rrts_pkg::NUM_SLOTS];
  logic [rrts_pkg::PID_W-1:0]     owner_q;
  logic                           own_re;
  logic                           own_we;
  logic [rrts_pkg::SLOT_W-1:0]    own_addr;

  logic                           req_acc;
  logic                           rsp_load;
  logic                           out_free;
  logic [rrts_pkg::SLOT_W-1:0]    t;
  logic                           found;
  logic                           t_is_run;
  logic [rrts_pkg::TS_W-1:0]      tc_inc;
  logic                           tick_due;
  logic [rrts_pkg::SLOT_W-1:0]    idx_inc;
  logic [rrts_pkg::SLOT_W-1:0]    run_inc;
  logic                           cand_hit;
  logic                           owner_match;
  logic                           idx_last;

  assign req_acc     = req_valid && !req_stall;
  assign out_free    = !rsp_valid || !rsp_stall;
  assign t           = rrts_pkg::tid_to_slot(tid);
  assign found       = rrts_pkg::tid_in_range(tid) && used[t];
  assign t_is_run    = (t == run);
  assign tc_inc      = tick_count + 8'd1;
  assign tick_due    = (tc_inc >= timeslice);
  assign idx_last    = (idx == rrts_pkg::SLOT_LAST);
  assign idx_inc     = idx_last ? '0 : idx + 1'b1;
  assign run_inc     = (run == rrts_pkg::SLOT_LAST) ? '0 : run + 1'b1;
  assign cand_hit    = used[idx] && ready[idx];
  assign owner_match = used[idx] && (owner_q == pid);

  always_comb begin
    state_next = state;
    case (state)
      rrts_pkg::S_IDLE: begin
        if (req_acc) state_next = rrts_pkg::S_DEC;
      end
      rrts_pkg::S_DEC: begin
        state_next = rrts_pkg::S_DONE;
        case (op)
          rrts_pkg::ACT_CREATE: state_next = rrts_pkg::S_FREE;
          rrts_pkg::ACT_YIELD: begin
            if (running) state_next = rrts_pkg::S_NEXT;
          end
          rrts_pkg::ACT_DELETE: begin
            if (running && found && t_is_run) state_next = rrts_pkg::S_NEXT;
          end
          rrts_pkg::ACT_BLOCK: begin
            if (running && found && !wake[t] && t_is_run) state_next = rrts_pkg::S_NEXT;
          end
          rrts_pkg::ACT_PBLOCK, rrts_pkg::ACT_PUNBLOCK: state_next = rrts_pkg::S_PRD;
          rrts_pkg::ACT_TICK: begin
            if (tick_due && running) state_next = rrts_pkg::S_NEXT;
          end
          default: state_next = rrts_pkg::S_DONE;
        endcase
      end
      rrts_pkg::S_FREE: begin
        if (!used[idx] || idx_last) state_next = rrts_pkg::S_DONE;
      end
      rrts_pkg::S_NEXT: begin
        if (cand_hit) state_next = rrts_pkg::S_OWN_RUN;
        else if (cnt == rrts_pkg::SLOT_LAST) state_next = rrts_pkg::S_DONE;
      end
      rrts_pkg::S_OWN_RUN: state_next = rrts_pkg::S_OWN_NEW;
      rrts_pkg::S_OWN_NEW: state_next = rrts_pkg::S_SWITCH;
      rrts_pkg::S_SWITCH:  state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_PRD:     state_next = rrts_pkg::S_PCMP;
      rrts_pkg::S_PCMP: begin
        state_next = idx_last ? rrts_pkg::S_DONE : rrts_pkg::S_PRD;
      end
      rrts_pkg::S_DONE: begin
        if (out_free) state_next = rrts_pkg::S_IDLE;
      end
      default: state_next = rrts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    own_re    = 1'b0;
    own_we    = 1'b0;
    own_addr  = idx;
    rsp_load  = 1'b0;
    case (state)
      rrts_pkg::S_IDLE:    req_stall = 1'b0;
      rrts_pkg::S_FREE:    own_we = !used[idx];
      rrts_pkg::S_OWN_RUN: begin
        own_re   = 1'b1;
        own_addr = run;
      end
      rrts_pkg::S_OWN_NEW: own_re = 1'b1;
      rrts_pkg::S_PRD:     own_re = 1'b1;
      rrts_pkg::S_DONE:    rsp_load = out_free;
      default: begin
        own_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (own_we) slot_owner[idx] <= pid;
    if (own_re) owner_q <= slot_owner[own_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rrts_pkg::S_IDLE;
      used       <= '0;
      ready      <= '0;
      wake       <= '0;
      run        <= '0;
      running    <= 1'b0;
      tick_count <= '0;
      timeslice  <= rrts_pkg::TIMESLICE_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) timeslice <= cfg_data;
      case (state)
        rrts_pkg::S_IDLE: begin
          if (req_acc) begin
            op     <= req.action;
            tid    <= req.thread_id;
            pid    <= req.process_id;
            status <= rrts_pkg::ST_OK;
            newt   <= '0;
            sw     <= 1'b0;
            sp     <= 1'b0;
            any    <= 1'b0;
          end
        end
        rrts_pkg::S_DEC: begin
          cnt <= rrts_pkg::SLOT_W'(1);
          idx <= run_inc;
          case (op)
            rrts_pkg::ACT_CREATE, rrts_pkg::ACT_PBLOCK, rrts_pkg::ACT_PUNBLOCK: begin
              idx <= '0;
            end
            rrts_pkg::ACT_YIELD: begin
              if (!running) status <= rrts_pkg::ST_IDLE;
            end
            rrts_pkg::ACT_DELETE: begin
              if (!running) begin
                status <= rrts_pkg::ST_IDLE;
              end else if (!found) begin
                status <= rrts_pkg::ST_NOT_FOUND;
              end else if (!t_is_run) begin
                used[t]  <= 1'b0;
                ready[t] <= 1'b0;
                wake[t]  <= 1'b0;
              end
            end
            rrts_pkg::ACT_BLOCK: begin
              if (!running) begin
                status <= rrts_pkg::ST_IDLE;
              end else if (!found) begin
                status <= rrts_pkg::ST_NOT_FOUND;
              end else if (wake[t]) begin
                wake[t] <= 1'b0;
              end else begin
                ready[t] <= 1'b0;
              end
            end
            rrts_pkg::ACT_UNBLOCK: begin
              if (!running) begin
                status <= rrts_pkg::ST_IDLE;
              end else if (!found) begin
                status <= rrts_pkg::ST_NOT_FOUND;
              end else begin
                ready[t] <= 1'b1;
                wake[t]  <= 1'b1;
              end
            end
            rrts_pkg::ACT_TICK: begin
              if (tick_due) begin
                tick_count <= '0;
                if (!running) status <= rrts_pkg::ST_IDLE;
              end else begin
                tick_count <= tc_inc;
              end
            end
            default: begin
              status <= rrts_pkg::ST_OK;
            end
          endcase
        end
        rrts_pkg::S_FREE: begin
          if (!used[idx]) begin
            used[idx]  <= 1'b1;
            ready[idx] <= !running;
            wake[idx]  <= 1'b0;
            newt       <= rrts_pkg::slot_to_tid(idx);
            if (!running) begin
              run     <= idx;
              running <= 1'b1;
              sw      <= 1'b1;
              sp      <= 1'b1;
            end
          end else if (idx_last) begin
            status <= rrts_pkg::ST_FULL;
          end else begin
            idx <= idx_inc;
          end
        end
        rrts_pkg::S_NEXT: begin
          if (!cand_hit) begin
            if (cnt == rrts_pkg::SLOT_LAST) begin
              status <= rrts_pkg::ST_NO_OTHER;
            end else begin
              idx <= idx_inc;
              cnt <= cnt + 1'b1;
            end
          end
        end
        rrts_pkg::S_OWN_NEW: owner_a <= owner_q;
        rrts_pkg::S_SWITCH: begin
          sp        <= (owner_q != owner_a);
          sw        <= 1'b1;
          wake[idx] <= 1'b0;
          run       <= idx;
          if (op == rrts_pkg::ACT_DELETE) begin
            used[run]  <= 1'b0;
            ready[run] <= 1'b0;
            wake[run]  <= 1'b0;
          end
        end
        rrts_pkg::S_PCMP: begin
          if (owner_match) begin
            ready[idx] <= (op == rrts_pkg::ACT_PUNBLOCK);
            any        <= 1'b1;
          end
          if (idx_last) begin
            if (!(any || owner_match)) status <= rrts_pkg::ST_NOT_FOUND;
          end else begin
            idx <= idx_inc;
          end
        end
        default: begin
          any <= any;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status         <= status;
      rsp.new_thread     <= newt;
      rsp.running_thread <= running ? rrts_pkg::slot_to_tid(run) : '0;
      rsp.running_valid  <= running;
      rsp.switched       <= sw;
      rsp.space_switch   <= sp;
    end
  end

`ifndef ASSERT_OFF
  a_run_used: assert property (@(posedge clk) disable iff (rst)
    running |-> used[run])
    else $error("running thread occupies a free slot");

  a_next_running: assert property (@(posedge clk) disable iff (rst)
    state == rrts_pkg::S_NEXT |-> running)
    else $error("reschedule scan with no running thread");

  a_switch_other: assert property (@(posedge clk) disable iff (rst)
    state == rrts_pkg::S_SWITCH |-> idx != run)
    else $error("switch target equals the running slot");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == rrts_pkg::S_DEC)
    else $error("accepted transaction not decoded");

  a_switch_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.switched |-> rsp.running_valid)
    else $error("switch reported with nothing running");
`endif

endmodule
